// ===== hw/rtl/rsct_pkg.sv =====
// ---------------------------------------------------------------------------
// rsct_pkg: shared definitions of the resizing stack capacity tracker
// Widths, register indexes, reset values, multiplier operand codes and the
// command and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package rsct_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int DATA_W    = 32;
  localparam int CNT_OUT_W = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int RATIO_W   = 8;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROW_RATIO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHRINK_RATIO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_CAP     = 3'd4;

  localparam logic [RATIO_W-1:0] UPPER_LIMIT_RST  = 8'd218;
  localparam logic [RATIO_W-1:0] LOWER_LIMIT_RST  = 8'd38;
  localparam logic [RATIO_W-1:0] GROW_RATIO_RST   = 8'd32;
  localparam logic [RATIO_W-1:0] SHRINK_RATIO_RST = 8'd8;
  localparam logic [CFG_W-1:0]   INIT_CAP_RST     = 11'd10;

  // A pop may shrink the capacity only when the new top index is above this.
  localparam int MIN_SHRINK_TOP = 10;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Operand select of the shared capacity multiplier.
  localparam logic [1:0] MUL_GROW   = 2'd0;
  localparam logic [1:0] MUL_SHRINK = 2'd1;
  localparam logic [1:0] MUL_UPPER  = 2'd2;
  localparam logic [1:0] MUL_LOWER  = 2'd3;

  typedef struct packed {
    logic [RATIO_W-1:0] upper_limit;
    logic [RATIO_W-1:0] lower_limit;
    logic [RATIO_W-1:0] grow_ratio;
    logic [RATIO_W-1:0] shrink_ratio;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic [CFG_W-1:0] value;
  } init_load_t;

  typedef struct packed {
    logic       start_item;
    logic [1:0] mul_op;
    logic       apply_grow;
    logic       apply_shrink;
    logic       do_store;
    logic       do_pop;
    logic       latch_pop;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic can_store;
    logic nonempty;
    logic up_hit;
    logic low_hit;
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rsct_cfg.sv =====
// ---------------------------------------------------------------------------
// rsct_cfg: configuration registers
// Holds the threshold and ratio registers and the initial capacity, and
// forwards a write of the initial capacity as a load beat to the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module rsct_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [rsct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rsct_pkg::CFG_W-1:0]     cfg_data,
  output rsct_pkg::cfg_t                      cfg,
  output rsct_pkg::init_load_t                init_load
);

  logic [rsct_pkg::CFG_W-1:0] init_cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.upper_limit  <= rsct_pkg::UPPER_LIMIT_RST;
      cfg.lower_limit  <= rsct_pkg::LOWER_LIMIT_RST;
      cfg.grow_ratio   <= rsct_pkg::GROW_RATIO_RST;
      cfg.shrink_ratio <= rsct_pkg::SHRINK_RATIO_RST;
      init_cap         <= rsct_pkg::INIT_CAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rsct_pkg::REG_UPPER_LIMIT:  cfg.upper_limit  <= cfg_data[rsct_pkg::RATIO_W-1:0];
        rsct_pkg::REG_LOWER_LIMIT:  cfg.lower_limit  <= cfg_data[rsct_pkg::RATIO_W-1:0];
        rsct_pkg::REG_GROW_RATIO:   cfg.grow_ratio   <= cfg_data[rsct_pkg::RATIO_W-1:0];
        rsct_pkg::REG_SHRINK_RATIO: cfg.shrink_ratio <= cfg_data[rsct_pkg::RATIO_W-1:0];
        rsct_pkg::REG_INIT_CAP:     init_cap         <= cfg_data;
        default: ;
      endcase
    end
  end

  // The datapath reloads capacity and peak from the written value at once.
  assign init_load.load  = cfg_we && (cfg_index == rsct_pkg::REG_INIT_CAP);
  assign init_load.value = init_load.load ? cfg_data : init_cap;

endmodule

`default_nettype wire

// ===== hw/rtl/rsct_ctrl.sv =====
// ---------------------------------------------------------------------------
// rsct_ctrl: operation sequencer
// Steps one push or pop through grow test, store or read, threshold test
// and resize, then strobes the result for one cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rsct_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            kind,
  input  rsct_pkg::status_t    st,
  output rsct_pkg::cmd_t       cmd,
  output logic                 busy,
  output logic                 done
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_P_TEST   = 4'd1;
  localparam logic [3:0] S_P_GROW   = 4'd2;
  localparam logic [3:0] S_P_STORE  = 4'd3;
  localparam logic [3:0] S_P_UCHK   = 4'd4;
  localparam logic [3:0] S_P_GROW2  = 4'd5;
  localparam logic [3:0] S_O_READ   = 4'd6;
  localparam logic [3:0] S_O_LCHK   = 4'd7;
  localparam logic [3:0] S_O_SHRINK = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    cmd              = '0;
    cmd.mul_op       = rsct_pkg::MUL_GROW;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.start_item = 1'b1;
          state_next     = (kind == rsct_pkg::KIND_POP) ? S_O_READ : S_P_TEST;
        end
      end
      S_P_TEST: begin
        cmd.mul_op = rsct_pkg::MUL_GROW;
        state_next = st.full ? S_P_GROW : S_P_STORE;
      end
      S_P_GROW: begin
        cmd.apply_grow = 1'b1;
        state_next     = S_P_STORE;
      end
      S_P_STORE: begin
        cmd.mul_op = rsct_pkg::MUL_UPPER;
        if (st.can_store) begin
          cmd.do_store = 1'b1;
          state_next   = S_P_UCHK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_P_UCHK: begin
        cmd.mul_op = rsct_pkg::MUL_GROW;
        state_next = st.up_hit ? S_P_GROW2 : S_DONE;
      end
      S_P_GROW2: begin
        cmd.apply_grow = 1'b1;
        state_next     = S_DONE;
      end
      S_O_READ: begin
        cmd.mul_op = rsct_pkg::MUL_LOWER;
        if (st.nonempty) begin
          cmd.do_pop = 1'b1;
          state_next = S_O_LCHK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_O_LCHK: begin
        cmd.latch_pop = 1'b1;
        cmd.mul_op    = rsct_pkg::MUL_SHRINK;
        state_next    = st.low_hit ? S_O_SHRINK : S_DONE;
      end
      S_O_SHRINK: begin
        cmd.apply_shrink = 1'b1;
        state_next       = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not start an operation");

  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block stayed busy after the result beat");

  a_grow2_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_P_GROW2 || state == S_O_SHRINK) |=> done)
    else $error("final resize not followed by the result beat");

endmodule

`default_nettype wire

// ===== hw/rtl/rsct_dp.sv =====
// ---------------------------------------------------------------------------
// rsct_dp: stack datapath
// Stack memory, occupancy, capacity, peak and resize counters, the shared
// capacity multiplier and the threshold comparators.
// ---------------------------------------------------------------------------
`default_nettype none

module rsct_dp #(
  parameter int DEPTH = rsct_pkg::DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  rsct_pkg::cmd_t                       cmd,
  input  rsct_pkg::cfg_t                       cfg,
  input  rsct_pkg::init_load_t                 init_load,
  input  wire logic [rsct_pkg::DATA_W-1:0]     push_value,
  output rsct_pkg::status_t                    st,
  output logic [rsct_pkg::DATA_W-1:0]          pop_value,
  output logic                                 accepted,
  output logic [rsct_pkg::CNT_OUT_W-1:0]       occupancy,
  output logic [rsct_pkg::CNT_OUT_W-1:0]       capacity,
  output logic [rsct_pkg::CNT_OUT_W-1:0]       peak_capacity,
  output logic [rsct_pkg::DATA_W-1:0]          resize_total
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int PW = CW + rsct_pkg::RATIO_W;
  localparam int NW = PW - 4;

  // The reset capacity is below the smallest allowed depth.
  localparam logic [CW-1:0] RST_CAP = CW'(rsct_pkg::INIT_CAP_RST);

  logic [rsct_pkg::DATA_W-1:0] mem [DEPTH];
  logic [rsct_pkg::DATA_W-1:0] rd_q;
  logic [rsct_pkg::DATA_W-1:0] word_q;
  logic [rsct_pkg::DATA_W-1:0] pop_q;
  logic [rsct_pkg::DATA_W-1:0] resize_cnt;
  logic                        ok_q;
  logic [CW-1:0]               count;
  logic [CW-1:0]               cap;
  logic [CW-1:0]               peak;
  logic [PW-1:0]               mul_q;
  logic [rsct_pkg::RATIO_W-1:0] mul_opnd;
  logic [CW-1:0]               top;
  logic [PW-1:0]               top_scaled;
  logic [NW-1:0]               grow_raw;
  logic [NW-1:0]               shrink_raw;
  logic [CW-1:0]               grow_cap;
  logic [CW-1:0]               shrink_cap;
  logic [CW-1:0]               new_cap;
  logic [31:0]                 init_ext;
  logic [CW-1:0]               init_cap;

  always_comb begin
    case (cmd.mul_op)
      rsct_pkg::MUL_GROW:   mul_opnd = cfg.grow_ratio;
      rsct_pkg::MUL_SHRINK: mul_opnd = cfg.shrink_ratio;
      rsct_pkg::MUL_UPPER:  mul_opnd = cfg.upper_limit;
      rsct_pkg::MUL_LOWER:  mul_opnd = cfg.lower_limit;
      default:              mul_opnd = cfg.grow_ratio;
    endcase
  end

  // The product of the current capacity is registered, ready in the cycle after the select.
  always_ff @(posedge clk) begin
    mul_q <= PW'(cap) * PW'(mul_opnd);
  end

  assign top        = count - CW'(1);
  assign top_scaled = {top, 8'd0};

  // Ratios are Q4.4, so the new capacity is the product without four bits.
  assign grow_raw   = mul_q[PW-1:4];
  assign shrink_raw = (mul_q[PW-1:4] < NW'(count)) ? NW'(count) : mul_q[PW-1:4];
  assign grow_cap   = (grow_raw > NW'(DEPTH)) ? CW'(DEPTH) : grow_raw[CW-1:0];
  assign shrink_cap = (shrink_raw > NW'(DEPTH)) ? CW'(DEPTH) : shrink_raw[CW-1:0];
  assign new_cap    = cmd.apply_shrink ? shrink_cap : grow_cap;

  assign init_ext = 32'(init_load.value);
  assign init_cap = (init_ext > 32'(DEPTH)) ? CW'(DEPTH) : init_ext[CW-1:0];

  assign st.full      = (count >= cap);
  assign st.can_store = (count < cap) && (count < CW'(DEPTH));
  assign st.nonempty  = (count != '0);
  assign st.up_hit    = (top_scaled > mul_q);
  assign st.low_hit   = (count > CW'(rsct_pkg::MIN_SHRINK_TOP + 1)) && (top_scaled < mul_q);

  always_ff @(posedge clk) begin
    if (cmd.do_store) begin
      mem[count[AW-1:0]] <= word_q;
    end
    if (cmd.do_pop) begin
      rd_q <= mem[top[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_item) begin
      word_q <= push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      cap        <= RST_CAP;
      peak       <= RST_CAP;
      resize_cnt <= '0;
      ok_q       <= 1'b0;
      pop_q      <= '0;
    end else begin
      if (init_load.load) begin
        cap  <= init_cap;
        peak <= init_cap;
      end
      if (cmd.start_item) begin
        ok_q  <= 1'b0;
        pop_q <= '0;
      end
      if (cmd.do_store) begin
        count <= count + CW'(1);
        ok_q  <= 1'b1;
      end
      if (cmd.do_pop) begin
        count <= top;
        ok_q  <= 1'b1;
      end
      if (cmd.latch_pop) begin
        pop_q <= rd_q;
      end
      if (cmd.apply_grow || cmd.apply_shrink) begin
        cap <= new_cap;
        if (new_cap > peak) begin
          peak <= new_cap;
        end
        if (resize_cnt != '1) begin
          resize_cnt <= resize_cnt + 32'd1;
        end
      end
    end
  end

  assign pop_value     = pop_q;
  assign accepted      = ok_q;
  assign occupancy     = rsct_pkg::CNT_OUT_W'(count);
  assign capacity      = rsct_pkg::CNT_OUT_W'(cap);
  assign peak_capacity = rsct_pkg::CNT_OUT_W'(peak);
  assign resize_total  = resize_cnt;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    (peak >= cap) && (peak <= CW'(DEPTH)))
    else $error("peak capacity inconsistent with capacity");

  a_store_room: assert property (@(posedge clk) disable iff (rst)
    cmd.do_store |-> (count < cap))
    else $error("store issued into a full stack");

endmodule

`default_nettype wire

// ===== hw/rtl/resizing_stack_capacity_tracker_top.sv =====
// ---------------------------------------------------------------------------
// resizing_stack_capacity_tracker_top: resizing stack with capacity tracking
// Stack of signed words whose logical capacity grows and shrinks by
// fixed-point ratios, with resize count and peak capacity.
// ---------------------------------------------------------------------------
// An operation is taken when start is high while busy is low. Its result is
// shown for exactly one cycle, marked by done, and must be captured then.
// A pop reads the stack and, when it was nonempty, tests the lower
// threshold and may shrink the capacity; a push tests for a grow, may
// grow, stores and, when stored, tests the upper threshold and may grow
// again. The next start is taken in the cycle after done. The steps wait
// on the shared capacity multiplier, whose product is registered before
// each threshold test or resize, and on the registered read of the stack
// memory. Reset needs no clearing pass; a write of the initial capacity
// also reloads capacity and peak capacity.
`default_nettype none

module resizing_stack_capacity_tracker_top #(
  parameter int DEPTH = rsct_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              kind,
  input  wire logic signed [rsct_pkg::DATA_W-1:0] push_value,
  output logic                                   done,
  output logic signed [rsct_pkg::DATA_W-1:0]     pop_value,
  output logic                                   accepted,
  output logic [rsct_pkg::CNT_OUT_W-1:0]         occupancy,
  output logic [rsct_pkg::CNT_OUT_W-1:0]         capacity,
  output logic [rsct_pkg::CNT_OUT_W-1:0]         peak_capacity,
  output logic [rsct_pkg::DATA_W-1:0]            resize_total,
  input  wire logic                              cfg_we,
  input  wire logic [rsct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rsct_pkg::CFG_W-1:0]        cfg_data
);

  rsct_pkg::cfg_t       cfg;
  rsct_pkg::init_load_t init_load;
  rsct_pkg::cmd_t       cmd;
  rsct_pkg::status_t    st;
  logic [rsct_pkg::DATA_W-1:0] pop_word;

  rsct_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .init_load (init_load)
  );

  rsct_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  rsct_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg           (cfg),
    .init_load     (init_load),
    .push_value    (push_value),
    .st            (st),
    .pop_value     (pop_word),
    .accepted      (accepted),
    .occupancy     (occupancy),
    .capacity      (capacity),
    .peak_capacity (peak_capacity),
    .resize_total  (resize_total)
  );

  assign pop_value = signed'(pop_word);

endmodule

`default_nettype wire
